[rtl/ccfp_pkg.sv]
// ----------------------------------------------------------------------------
// ccfp_pkg
// Shared types, character codes and helper functions for the command frame
// parser with CRC-16 check.
// ----------------------------------------------------------------------------
package ccfp_pkg;

  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChNul   = 8'h00;

  localparam logic [2:0] StDrive   = 3'd0;
  localparam logic [2:0] StLift    = 3'd1;
  localparam logic [2:0] StCrc     = 3'd2;
  localparam logic [2:0] StFormat  = 3'd3;
  localparam logic [2:0] StUnknown = 3'd4;

  localparam logic [1:0] RegMaxDrive = 2'd0;
  localparam logic [1:0] RegSteerMin = 2'd1;
  localparam logic [1:0] RegSteerMax = 2'd2;

  localparam logic [2:0] TrailerBad = 3'd7;
  localparam logic [2:0] TrailerLen = 3'd4;
  localparam logic [32:0] AccCap    = 33'h1_0000_0000;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam int NumActions = 5;

  localparam logic [7:0] CmdPrefix [4] = '{8'h43, 8'h4D, 8'h44, 8'h2C};
  localparam logic [7:0] LiftPrefix [5] = '{8'h4C, 8'h49, 8'h46, 8'h54, 8'h2C};
  localparam logic [3:0] ActionLens [NumActions] = '{4'd2, 4'd4, 4'd4, 4'd10, 4'd4};
  localparam logic [7:0] ActionWords [NumActions][10] = '{
    '{8'h55, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h44, 8'h4F, 8'h57, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h48, 8'h4F, 8'h4D, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h49, 8'h4E, 8'h49, 8'h54, 8'h49, 8'h41, 8'h4C, 8'h49, 8'h5A, 8'h45},
    '{8'h53, 8'h54, 8'h4F, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  typedef struct packed {
    logic       zero;
    logic       bad;
    logic       neg;
    logic       digits;
    logic [1:0] idx;
  } fs_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [31:0]       seq;
    logic signed [7:0] drive;
    logic [15:0]       steer;
    logic [2:0]        action;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      crc = crc[15] ? ({crc[14:0], 1'b0} ^ CrcPoly) : {crc[14:0], 1'b0};
    end
    return crc;
  endfunction

  function automatic logic [32:0] add_digit(input logic [32:0] acc, input logic [7:0] c);
    logic [36:0] t;
    t = 37'({acc, 3'b000}) + 37'({acc, 1'b0}) + 37'(c[3:0]);
    return (t > 37'(AccCap)) ? AccCap : t[32:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // returns {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (is_digit(c)) r = {1'b1, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    return r;
  endfunction

  function automatic logic action_match(input logic [2:0] w, input logic [3:0] pos,
                                        input logic [7:0] c);
    logic m;
    m = 1'b0;
    if (pos < ActionLens[w]) m = (ActionWords[w][pos] == c);
    return m;
  endfunction

endpackage

[rtl/ccfp_parser.sv]
// ----------------------------------------------------------------------------
// ccfp_parser
// Per-byte frame state: prefix match, CRC, trailer, field parse and the
// snapshot taken at each star. Builds the result when LF closes a frame.
// ----------------------------------------------------------------------------
module ccfp_parser #(
  parameter int MAX_FRAME = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [6:0]        max_drive_i,
  input  logic [15:0]       steer_min_i,
  input  logic [15:0]       steer_max_i,
  output logic              res_valid_o,
  output ccfp_pkg::result_t res_o
);
  import ccfp_pkg::*;

  localparam int BCW = $clog2(MAX_FRAME);

  logic           in_frame_q, in_frame_d;
  logic [BCW-1:0] bc_q, bc_d;
  logic [1:0]     tm_q, tm_d;
  logic [15:0]    crc_q, crc_d, crc_star_q, crc_star_d;
  logic [15:0]    tv_q, tv_d;
  logic [2:0]     tc_q, tc_d;
  fs_t            fs_q, fs_d, fss_q, fss_d;
  logic [32:0]    seq_q, seq_d, seqs_q, seqs_d;
  logic [32:0]    drv_q, drv_d, drvs_q, drvs_d;
  logic [32:0]    str_q, str_d, strs_q, strs_d;

  logic [7:0]     c;
  logic [4:0]     hv;
  logic [3:0]     lpos;
  logic           is_cmd, is_lift, found;
  result_t        res;

  assign c  = rx_byte_i;
  assign hv = hex_val(c);
  assign lpos = str_q[3:0];

  always_comb begin
    in_frame_d = in_frame_q;
    bc_d = bc_q;
    tm_d = tm_q;
    crc_d = crc_q;
    crc_star_d = crc_star_q;
    tv_d = tv_q;
    tc_d = tc_q;
    fs_d = fs_q;
    fss_d = fss_q;
    seq_d = seq_q;
    seqs_d = seqs_q;
    drv_d = drv_q;
    drvs_d = drvs_q;
    str_d = str_q;
    strs_d = strs_q;
    res_valid_o = 1'b0;
    if (fire_i) begin
      if (c == ChAt) begin
        in_frame_d = 1'b1;
        bc_d = BCW'(1);
        tm_d = 2'b11;
        crc_d = CrcInit;
        crc_star_d = CrcInit;
        tv_d = '0;
        tc_d = TrailerBad;
        fs_d = '0;
        fss_d = '0;
        seq_d = '0;
        seqs_d = '0;
        drv_d = '0;
        drvs_d = '0;
        str_d = '0;
        strs_d = '0;
      end else if (in_frame_q && c != ChCr) begin
        if (c == ChLf) begin
          in_frame_d = 1'b0;
          res_valid_o = 1'b1;
        end else if (bc_q >= BCW'(MAX_FRAME - 1)) begin
          // overlong frame is dropped silently
          in_frame_d = 1'b0;
        end else begin
          bc_d = bc_q + BCW'(1);
          if (bc_q <= BCW'(4) && c != CmdPrefix[bc_q[1:0] - 2'd1]) tm_d[0] = 1'b0;
          if (bc_q <= BCW'(5) && c != LiftPrefix[3'(bc_q[2:0] - 3'd1)]) tm_d[1] = 1'b0;
          if (c == ChNul) fs_d.zero = 1'b1;
          if (c == ChStar) begin
            crc_star_d = crc_q;
            fss_d = fs_q;
            seqs_d = seq_q;
            drvs_d = drv_q;
            strs_d = str_q;
            tv_d = '0;
            tc_d = '0;
          end else if (hv[4] && tc_q < TrailerLen) begin
            tv_d = {tv_q[11:0], hv[3:0]};
            tc_d = tc_q + 3'd1;
          end else begin
            tc_d = TrailerBad;
          end
          crc_d = crc_byte(crc_q, c);

          if (tm_q[0] && bc_q > BCW'(4)) begin
            if (!fs_q.bad) begin
              if (c == ChComma) begin
                if (fs_q.idx >= 2'd2 || !fs_q.digits) fs_d.bad = 1'b1;
                else begin
                  fs_d.idx = fs_q.idx + 2'd1;
                  fs_d.digits = 1'b0;
                end
              end else if (c == ChMinus) begin
                if (fs_q.idx == 2'd1 && !fs_q.digits && !fs_q.neg) fs_d.neg = 1'b1;
                else fs_d.bad = 1'b1;
              end else if (is_digit(c)) begin
                fs_d.digits = 1'b1;
                if (fs_q.idx == 2'd0) seq_d = add_digit(seq_q, c);
                else if (fs_q.idx == 2'd1) drv_d = add_digit(drv_q, c);
                else str_d = add_digit(str_q, c);
              end else begin
                fs_d.bad = 1'b1;
              end
            end
          end else if (tm_q[1] && bc_q > BCW'(5)) begin
            if (!fs_q.bad) begin
              if (fs_q.idx == 2'd0) begin
                if (c == ChComma) begin
                  if (!fs_q.digits) fs_d.bad = 1'b1;
                  else begin
                    fs_d.idx = 2'd1;
                    fs_d.digits = 1'b0;
                    drv_d = 33'h1F;  // all action words still possible
                    str_d = '0;
                  end
                end else if (is_digit(c)) begin
                  fs_d.digits = 1'b1;
                  seq_d = add_digit(seq_q, c);
                end else begin
                  fs_d.bad = 1'b1;
                end
              end else if (c == ChComma) begin
                fs_d.bad = 1'b1;
              end else begin
                for (int w = 0; w < NumActions; w++) begin
                  if (!action_match(3'(w), lpos, c)) drv_d[w] = 1'b0;
                end
                if (lpos < 4'd15) str_d = {29'd0, lpos + 4'd1};
              end
            end
          end
        end
      end
    end
  end

  // result from the state that stands before the LF
  always_comb begin
    res = '0;
    found = 1'b0;
    is_cmd = tm_q[0] && bc_q >= BCW'(5);
    is_lift = tm_q[1] && bc_q >= BCW'(6);
    res.status = StFormat;
    if (!is_cmd && !is_lift) begin
      res.status = StUnknown;
    end else if (fs_q.zero || tc_q != TrailerLen) begin
      res.status = StFormat;
    end else if (crc_star_q != tv_q) begin
      res.status = StCrc;
    end else if (is_cmd) begin
      if (!fss_q.bad && fss_q.idx == 2'd2 && fss_q.digits && seqs_q < AccCap &&
          drvs_q <= {26'd0, max_drive_i} &&
          strs_q >= {17'd0, steer_min_i} && strs_q <= {17'd0, steer_max_i}) begin
        res.status = StDrive;
        res.seq = seqs_q[31:0];
        res.drive = fss_q.neg ? (8'd0 - drvs_q[7:0]) : drvs_q[7:0];
        res.steer = strs_q[15:0];
      end
    end else begin
      if (!fss_q.bad && fss_q.idx == 2'd1 && seqs_q < AccCap) begin
        for (int w = 0; w < NumActions; w++) begin
          if (!found && drvs_q[w] && strs_q == {29'd0, ActionLens[w]}) begin
            found = 1'b1;
            res.status = StLift;
            res.seq = seqs_q[31:0];
            res.action = 3'(w);
          end
        end
      end
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      bc_q <= '0;
      tm_q <= '0;
      crc_q <= CrcInit;
      crc_star_q <= CrcInit;
      tv_q <= '0;
      tc_q <= '0;
      fs_q <= '0;
      fss_q <= '0;
      seq_q <= '0;
      seqs_q <= '0;
      drv_q <= '0;
      drvs_q <= '0;
      str_q <= '0;
      strs_q <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      bc_q <= bc_d;
      tm_q <= tm_d;
      crc_q <= crc_d;
      crc_star_q <= crc_star_d;
      tv_q <= tv_d;
      tc_q <= tc_d;
      fs_q <= fs_d;
      fss_q <= fss_d;
      seq_q <= seq_d;
      seqs_q <= seqs_d;
      drv_q <= drv_d;
      drvs_q <= drvs_d;
      str_q <= str_d;
      strs_q <= strs_d;
    end
  end

endmodule

[rtl/ccfp_out_buf.sv]
// ----------------------------------------------------------------------------
// ccfp_out_buf
// Result register with one skid entry, so the input side keeps taking
// words while a result waits on the output.
// ----------------------------------------------------------------------------
module ccfp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ccfp_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ccfp_pkg::result_t out_data_o
);
  import ccfp_pkg::*;

  logic    out_v_q, skid_v_q;
  result_t out_q, skid_q;
  logic    pop;

  assign pop = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q) begin
        out_v_q <= push_i;
      end else if (pop) begin
        if (skid_v_q) begin
          skid_v_q <= 1'b0;
        end else begin
          out_v_q <= push_i;
        end
      end else if (push_i) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || (pop && !skid_v_q)) begin
      out_q <= push_data_i;
    end else if (pop) begin
      out_q <= skid_q;
    end
    if (out_v_q && !pop && push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign full_o = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

endmodule

[rtl/crc_checked_command_frame_parser_top.sv]
// ----------------------------------------------------------------------------
// crc_checked_command_frame_parser_top
// Command frame parser with CRC-16/CCITT-FALSE trailer check.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while in_stall_o is low; the parser state update is registered
// the LF word's result is registered in the result register, or in the skid entry while an earlier result waits
// a result register plus one skid entry decouple output stalls from input
// reset clears frame state and loads register defaults; no clearing pass
module crc_checked_command_frame_parser_top #(
  parameter int MAX_FRAME = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        frame_status_o,
  output logic [31:0]       sequence_number_o,
  output logic signed [7:0] drive_percent_o,
  output logic [15:0]       steering_cdeg_o,
  output logic [2:0]        lift_action_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import ccfp_pkg::*;

  logic [6:0]  max_drive_q;
  logic [15:0] steer_min_q, steer_max_q;
  logic        fire, res_valid, full;
  result_t     res, out_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_drive_q <= 7'd100;
      steer_min_q <= 16'd0;
      steer_max_q <= 16'd18000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegMaxDrive: max_drive_q <= cfg_data_i[6:0];
        RegSteerMin: steer_min_q <= cfg_data_i;
        RegSteerMax: steer_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign fire = in_valid_i && !full;

  ccfp_parser #(
    .MAX_FRAME(MAX_FRAME)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .rx_byte_i  (rx_byte_i),
    .max_drive_i(max_drive_q),
    .steer_min_i(steer_min_q),
    .steer_max_i(steer_max_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  ccfp_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign frame_status_o    = out_data.status;
  assign sequence_number_o = out_data.seq;
  assign drive_percent_o   = out_data.drive;
  assign steering_cdeg_o   = out_data.steer;
  assign lift_action_o     = out_data.action;

endmodule
